@@ design/hhs_pkg.sv @@
package hhs_pkg;

  localparam int BUCKETS   = 1024;
  localparam int SLOTS     = 7;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int SLOT_IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NCNT_W    = 11;
  localparam int SLOT_BITS = 64;
  localparam int GUARD_LO  = SLOTS * SLOT_BITS;
  localparam int ROW_W     = GUARD_LO + 32;

  localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_B = 32'd3344921057;
  localparam int          HASH_SHIFT_A = 15;
  localparam int          HASH_SHIFT_B = 12;
  localparam int          DIV_BITS   = 32 - HASH_SHIFT_B;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

  localparam logic CFG_BUCKETS = 1'b0;
  localparam logic CFG_THRESH  = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_REPLACED = 2'd1,
    ST_GUARD    = 2'd2,
    ST_NOT_INS  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] flow_fingerprint;
    logic [31:0] increment;
  } in_item_t;

  typedef struct packed {
    logic [31:0] estimate;
    logic [1:0]  insert_status;
    logic        spilled;
  } out_item_t;

  typedef struct packed {
    logic go;
    logic second;
  } hash_req_t;

endpackage

@@ design/hhs_ram.sv @@
module hhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/hhs_hash.sv @@
module hhs_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hhs_pkg::hash_req_t        req,
  input  logic [hhs_pkg::NCNT_W-1:0] n,
  input  logic [31:0]               fp,
  output logic                      done,
  output logic [hhs_pkg::BKT_W-1:0] bucket
);
  import hhs_pkg::*;

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_LOAD = 3'b010,
    H_DIV  = 3'b100
  } hstate_t;

  hstate_t state_r, state_nxt;
  logic [31:0]         prod;
  logic                second_r;
  logic [DIV_BITS-1:0] div_r, div_nxt;
  logic [NCNT_W-1:0]   rem_r, rem_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [NCNT_W:0]     trial;

  always_comb begin
    state_nxt = state_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    trial     = {rem_r, div_r[DIV_BITS-1]};
    // The fingerprint is stable by the load cycle, the cycle after the request.
    prod      = fp * (second_r ? HASH_MUL_B : HASH_MUL_A);
    case (state_r)
      H_IDLE: begin
        if (req.go) begin
          state_nxt = H_LOAD;
        end
      end
      H_LOAD: begin
        // Both hashes are brought to the same dividend width.
        div_nxt   = second_r ? DIV_BITS'(prod >> HASH_SHIFT_B)
                             : DIV_BITS'(prod >> HASH_SHIFT_A);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = H_DIV;
      end
      H_DIV: begin
        // Restoring remainder, one dividend bit per cycle.
        if (trial >= {1'b0, n}) begin
          rem_nxt = NCNT_W'(trial - {1'b0, n});
        end else begin
          rem_nxt = NCNT_W'(trial);
        end
        div_nxt = {div_r[DIV_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_BITS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    if (state_r == H_IDLE && req.go) begin
      second_r <= req.second;
    end
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign bucket = BKT_W'(rem_r);

endmodule

@@ design/flow_heavy_hitter_sketch.sv @@
// Channel  Direction  Handshake              Payload
// input    in         start high, busy low   in_item (op, flow_fingerprint, increment)
// result   out        out_strobe, one cycle  out_item (estimate, insert_status, spilled)
// config   in         cfg_we                 cfg_index, cfg_wdata
//
// An insert or query visits a bucket in this order: the hash unit (operand load, a
// one-bit-per-cycle remainder over 20 dividend bits and its done cycle), one row read,
// a scan of the seven slots and a decide cycle; the result strobe follows the decide cycle.
// A spill or second query bucket runs the same sequence again.
// A clear writes one bucket row per cycle, all 1024 rows. After reset the same
// clearing pass runs while busy is high. Results cannot be stalled by the receiver.
module flow_heavy_hitter_sketch (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hhs_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output hhs_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import hhs_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_HASH   = 6'b000100,
    S_READ   = 6'b001000,
    S_SCAN   = 6'b010000,
    S_DECIDE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [NCNT_W-1:0] bcount_r;
  logic [31:0]       thresh_r;
  logic [NCNT_W-1:0] n_use;

  in_item_t   item_r;
  out_item_t  out_r, out_nxt;
  logic       strobe_r, strobe_nxt;
  logic       clr_op_r, clr_op_nxt;
  logic [BKT_W-1:0] clr_cnt_r, clr_cnt_nxt;

  hash_req_t        hreq;
  logic             hdone;
  logic [BKT_W-1:0] hbucket;
  logic [BKT_W-1:0] bucket_r, bucket_nxt;

  logic             ram_we, ram_re;
  logic [BKT_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic [SLOT_IW-1:0] idx_r, idx_nxt;
  logic               match_r, match_nxt, empty_r, empty_nxt;
  logic [SLOT_IW-1:0] match_idx_r, match_idx_nxt, free_idx_r, free_idx_nxt;
  logic [SLOT_IW-1:0] min_idx_r, min_idx_nxt;
  logic [31:0]        min_r, min_nxt, sum_r, sum_nxt;
  logic               pass2_r, pass2_nxt;

  logic [31:0] scan_fp, scan_cnt, match_cnt, guard_inc;
  logic [32:0] sat_sum;

  always_comb begin
    if (bcount_r == '0) begin
      n_use = NCNT_W'(1);
    end else if (bcount_r > NCNT_W'(BUCKETS)) begin
      n_use = NCNT_W'(BUCKETS);
    end else begin
      n_use = bcount_r;
    end
  end

  hhs_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (hreq),
    .n      (n_use),
    .fp     (item_r.flow_fingerprint),
    .done   (hdone),
    .bucket (hbucket)
  );

  hhs_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (bucket_r),
    .rdata (ram_rdata)
  );

  assign scan_fp   = ram_rdata[SLOT_BITS*idx_r +: 32];
  assign scan_cnt  = ram_rdata[SLOT_BITS*idx_r + 32 +: 32];
  assign match_cnt = ram_rdata[SLOT_BITS*match_idx_r + 32 +: 32];
  assign guard_inc = ram_rdata[GUARD_LO +: 32] + 32'd1;
  assign sat_sum   = {1'b0, match_cnt} + {1'b0, item_r.increment};

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    strobe_nxt    = 1'b0;
    clr_op_nxt    = clr_op_r;
    clr_cnt_nxt   = clr_cnt_r;
    bucket_nxt    = bucket_r;
    hreq          = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = bucket_r;
    ram_wdata     = ram_rdata;
    idx_nxt       = idx_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    empty_nxt     = empty_r;
    free_idx_nxt  = free_idx_r;
    min_nxt       = min_r;
    min_idx_nxt   = min_idx_r;
    sum_nxt       = sum_r;
    pass2_nxt     = pass2_r;
    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + BKT_W'(1);
        if (clr_cnt_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt   = S_IDLE;
          clr_cnt_nxt = '0;
          if (clr_op_r) begin
            strobe_nxt = 1'b1;
            out_nxt    = '{estimate: '0, insert_status: ST_NOT_INS, spilled: 1'b0};
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          pass2_nxt = 1'b0;
          sum_nxt   = '0;
          out_nxt   = '{estimate: '0, insert_status: ST_NOT_INS, spilled: 1'b0};
          case (op_t'(in_item.op))
            OP_INSERT, OP_QUERY: begin
              hreq.go   = 1'b1;
              state_nxt = S_HASH;
            end
            OP_CLEAR: begin
              clr_op_nxt  = 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_HASH: begin
        if (hdone) begin
          bucket_nxt = hbucket;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        ram_re        = 1'b1;
        idx_nxt       = '0;
        match_nxt     = 1'b0;
        empty_nxt     = 1'b0;
        min_nxt       = COUNT_MAX;
        min_idx_nxt   = '0;
        match_idx_nxt = '0;
        free_idx_nxt  = '0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (scan_fp == item_r.flow_fingerprint) begin
          sum_nxt = sum_r + scan_cnt;
          if (!match_r) begin
            match_nxt     = 1'b1;
            match_idx_nxt = idx_r;
          end
        end
        if (scan_cnt == '0 && !empty_r) begin
          empty_nxt    = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (scan_cnt < min_r) begin
          min_nxt     = scan_cnt;
          min_idx_nxt = idx_r;
        end
        idx_nxt = idx_r + SLOT_IW'(1);
        if (idx_r == SLOT_IW'(SLOTS - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        if (op_t'(item_r.op) == OP_QUERY) begin
          if (!pass2_r && min_r >= thresh_r) begin
            // The smallest count reached the threshold: add the second bucket too.
            pass2_nxt  = 1'b1;
            hreq       = '{go: 1'b1, second: 1'b1};
            strobe_nxt = 1'b0;
            state_nxt  = S_HASH;
          end else begin
            out_nxt.estimate = sum_r;
          end
        end else if (match_r) begin
          ram_we = 1'b1;
          ram_wdata[SLOT_BITS*match_idx_r + 32 +: 32] =
            sat_sum[32] ? COUNT_MAX : sat_sum[31:0];
          out_nxt.insert_status = ST_COUNTED;
        end else if (empty_r) begin
          ram_we = 1'b1;
          ram_wdata[SLOT_BITS*free_idx_r +: 32]      = item_r.flow_fingerprint;
          ram_wdata[SLOT_BITS*free_idx_r + 32 +: 32] = item_r.increment;
          out_nxt.insert_status = ST_COUNTED;
        end else if (!pass2_r && thresh_r != '0 && min_r >= thresh_r) begin
          pass2_nxt       = 1'b1;
          out_nxt.spilled = 1'b1;
          hreq            = '{go: 1'b1, second: 1'b1};
          strobe_nxt      = 1'b0;
          state_nxt       = S_HASH;
        end else if (guard_inc <= min_r) begin
          ram_we = 1'b1;
          ram_wdata[GUARD_LO +: 32] = guard_inc;
          out_nxt.insert_status = ST_GUARD;
        end else begin
          // The guard has overtaken the weakest slot, which changes owner.
          ram_we = 1'b1;
          ram_wdata[GUARD_LO +: 32]                 = '0;
          ram_wdata[SLOT_BITS*min_idx_r +: 32]      = item_r.flow_fingerprint;
          ram_wdata[SLOT_BITS*min_idx_r + 32 +: 32] = guard_inc;
          out_nxt.insert_status = ST_REPLACED;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      strobe_r  <= 1'b0;
      clr_op_r  <= 1'b0;
      clr_cnt_r <= '0;
      bcount_r  <= NCNT_W'(BUCKETS);
      thresh_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      strobe_r  <= strobe_nxt;
      clr_op_r  <= clr_op_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_we && cfg_index == CFG_BUCKETS) begin
        bcount_r <= cfg_wdata[NCNT_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_THRESH) begin
        thresh_r <= cfg_wdata;
      end
    end
    if (state_r == S_IDLE && start) begin
      item_r <= in_item;
    end
    out_r       <= out_nxt;
    bucket_r    <= bucket_nxt;
    idx_r       <= idx_nxt;
    match_r     <= match_nxt;
    match_idx_r <= match_idx_nxt;
    empty_r     <= empty_nxt;
    free_idx_r  <= free_idx_nxt;
    min_r       <= min_nxt;
    min_idx_r   <= min_idx_nxt;
    sum_r       <= sum_nxt;
    pass2_r     <= pass2_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule
